/* hdl/ttfd_pkg.sv */
// Shared constants, result types and the CRC-8 step for the turbine telemetry frame decoder.
// Depends on nothing; used by turbine_telemetry_frame_decoder.
package ttfd_pkg;

    // frame geometry
    localparam int FRAME_LEN    = 7;             // bytes in a good frame
    localparam int STORE_DEPTH  = FRAME_LEN - 1; // payload bytes kept (the frame's last byte, the CRC, is not kept)
    localparam int COUNT_W      = 4;
    localparam int COUNT_SAT    = 8;
    localparam int MAX_RES      = 5;
    localparam int RES_NUM_W    = 3;

    // field widths
    localparam int KIND_W  = 2;
    localparam int ID_W    = 5;
    localparam int VALUE_W = 21;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FIELD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECKSUM = 2'd2;

    // frame type nibble codes
    localparam logic [3:0] TYPE_STATUS   = 4'd1;
    localparam logic [3:0] TYPE_SUPPLY   = 4'd2;
    localparam logic [3:0] TYPE_THROTTLE = 4'd3;
    localparam logic [3:0] TYPE_THRUST   = 4'd4;
    localparam logic [3:0] TYPE_IGNITION = 4'd5;
    localparam logic [3:0] TYPE_LIMITS   = 4'd6;
    localparam logic [3:0] TYPE_FLOW     = 4'd7;
    localparam logic [3:0] TYPE_IDLE     = 4'd8;

    // field ids
    localparam logic [ID_W-1:0] FID_RPM        = 5'd0;
    localparam logic [ID_W-1:0] FID_STATUS     = 5'd1;
    localparam logic [ID_W-1:0] FID_ERROR      = 5'd2;
    localparam logic [ID_W-1:0] FID_TEMP       = 5'd3;
    localparam logic [ID_W-1:0] FID_SWITCH     = 5'd4;
    localparam logic [ID_W-1:0] FID_RC_VOLT    = 5'd5;
    localparam logic [ID_W-1:0] FID_PWR_VOLT   = 5'd6;
    localparam logic [ID_W-1:0] FID_PUMP_VOLT  = 5'd7;
    localparam logic [ID_W-1:0] FID_THROTTLE   = 5'd8;
    localparam logic [ID_W-1:0] FID_PRESSURE   = 5'd9;
    localparam logic [ID_W-1:0] FID_CURRENT    = 5'd10;
    localparam logic [ID_W-1:0] FID_THRUST     = 5'd11;
    localparam logic [ID_W-1:0] FID_IGN_VOLT   = 5'd12;
    localparam logic [ID_W-1:0] FID_RPM_ACCEL  = 5'd13;
    localparam logic [ID_W-1:0] FID_MAX_RPM    = 5'd14;
    localparam logic [ID_W-1:0] FID_PUMP_MAX   = 5'd15;
    localparam logic [ID_W-1:0] FID_VERSION    = 5'd16;
    localparam logic [ID_W-1:0] FID_UPD_RATE   = 5'd17;
    localparam logic [ID_W-1:0] FID_FLOW_RATE  = 5'd18;
    localparam logic [ID_W-1:0] FID_FLOW_TOTAL = 5'd19;
    localparam logic [ID_W-1:0] FID_IDLE_RPM   = 5'd20;

    // scaling and clamp limits
    localparam logic [7:0] THROTTLE_MAX = 8'd100;
    localparam logic [7:0] ACCEL_MIN    = 8'd10;
    localparam logic [7:0] ACCEL_MAX    = 8'd70;
    localparam int         TEMP_OFFSET  = 50;
    localparam logic [9:0] RPM_SCALE_K  = 10'd1000;
    localparam logic [7:0] CRC_POLY_REF = 8'h8C;

    // one queued result
    typedef struct packed {
        logic                      last;
        logic [KIND_W-1:0]         kind;
        logic [ID_W-1:0]           id;
        logic signed [VALUE_W-1:0] value;
    } t_res;

    // Dallas/Maxim CRC-8, reflected, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REF) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/turbine_telemetry_frame_decoder.sv */
// Top level of the turbine telemetry frame decoder: byte intake, CRC check and field decode.
// Depends on ttfd_pkg for constants, the result type and the CRC-8 step.
//
//  channel  | dir | tdata                         | tuser            | tlast
//  s_axis   | in  | [7:0] rx_byte                 | -                | packet_end
//  m_axis   | out | [4:0] field_id, [25:5] value  | [1:0] result_kind| last result of packet
//
// One byte is taken per cycle into the input register unless a packet end waits there; a plain
// byte is decoded there in the next cycle, and an end byte loads the queue with its results.
// A good frame, up to five results, leaves a five-entry shift queue one per cycle if ready.
// A packet end waits in the input register until the queue is empty or popping its last
// entry; plain bytes never wait. i_rst_n is synchronous: it clears valids, count and CRC.
module turbine_telemetry_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // packet_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] field_id, [25:5] field_value, [31:26] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast    // last
);

    localparam int MAX_RES = ttfd_pkg::MAX_RES;
    localparam int NUM_W = $clog2(MAX_RES + 1);
    localparam int IDX_W = $clog2(ttfd_pkg::STORE_DEPTH);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // frame state
    logic [7:0]                      r_frame [ttfd_pkg::STORE_DEPTH];
    logic [ttfd_pkg::COUNT_W-1:0]    r_count;
    logic [7:0]                      r_crc;

    // result queue
    ttfd_pkg::t_res   r_res [MAX_RES];
    logic [NUM_W-1:0] r_res_num;

    logic w_buf_free, w_advance, w_proc, w_pop;
    ttfd_pkg::t_res   n_res [MAX_RES];
    logic [NUM_W-1:0] n_res_num;

    // handshakes
    assign w_pop      = m_axis_tvalid && m_axis_tready;
    assign w_buf_free = (r_res_num == '0) || ((r_res_num == NUM_W'(1)) && m_axis_tready);
    assign w_advance  = !r_in_end || w_buf_free;
    assign w_proc     = r_in_vld && w_advance;
    assign s_axis_tready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    // payload bytes 0..5 kept; byte 6 is only ever compared as it arrives
    always_ff @(posedge i_clk) begin
        if (w_proc && (r_count < ttfd_pkg::COUNT_W'(ttfd_pkg::STORE_DEPTH))) begin
            r_frame[r_count[IDX_W-1:0]] <= r_in_byte;
        end
    end

    // byte count and running CRC, both cleared by any packet end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
        end else if (w_proc) begin
            if (r_in_end) begin
                r_count <= '0;
                r_crc   <= '0;
            end else begin
                if (r_count < ttfd_pkg::COUNT_W'(ttfd_pkg::STORE_DEPTH)) begin
                    r_crc <= ttfd_pkg::crc8_step(r_crc, r_in_byte);
                end
                if (r_count < ttfd_pkg::COUNT_W'(ttfd_pkg::COUNT_SAT)) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // decode of the finished packet into the queue image
    always_comb begin
        logic [7:0]  b0, b1, b2, b3, b4, b5;
        logic [15:0] rpm_raw;
        logic [10:0] temp_raw;
        logic [7:0]  accel;
        logic [17:0] kilo;
        logic        crc_ok, len_ok;
        logic [NUM_W-1:0] cnt;

        b0 = r_frame[0];
        b1 = r_frame[1];
        b2 = r_frame[2];
        b3 = r_frame[3];
        b4 = r_frame[4];
        b5 = r_frame[5];
        rpm_raw  = {b2, b1};
        temp_raw = {b4[4:2], b5};
        kilo     = 18'(b3) * 18'(ttfd_pkg::RPM_SCALE_K);
        accel    = (b4 < ttfd_pkg::ACCEL_MIN) ? ttfd_pkg::ACCEL_MIN :
                   ((b4 > ttfd_pkg::ACCEL_MAX) ? ttfd_pkg::ACCEL_MAX : b4);
        len_ok   = (r_count == ttfd_pkg::COUNT_W'(ttfd_pkg::STORE_DEPTH));
        crc_ok   = (r_crc == r_in_byte);

        for (int i = 0; i < MAX_RES; i++) begin
            n_res[i] = '0;
        end
        cnt = NUM_W'(1);

        if (!len_ok) begin
            n_res[0].kind = ttfd_pkg::KIND_LENGTH;
        end else if (!crc_ok) begin
            n_res[0].kind = ttfd_pkg::KIND_CHECKSUM;
        end else begin
            n_res[0].id    = ttfd_pkg::FID_RPM;
            n_res[0].value = $signed({1'b0, 20'({rpm_raw, 3'b000}) + 20'({rpm_raw, 1'b0})});
            unique case (b0[3:0])
                ttfd_pkg::TYPE_STATUS: begin
                    n_res[1].id    = ttfd_pkg::FID_STATUS;
                    n_res[1].value = $signed(21'({b3[4:0]}));
                    n_res[2].id    = ttfd_pkg::FID_ERROR;
                    n_res[2].value = $signed(21'({b4[1:0], b3[7:5]}));
                    n_res[3].id    = ttfd_pkg::FID_TEMP;
                    n_res[3].value = $signed(21'(temp_raw))
                                   - ttfd_pkg::VALUE_W'(ttfd_pkg::TEMP_OFFSET);
                    n_res[4].id    = ttfd_pkg::FID_SWITCH;
                    n_res[4].value = $signed(21'({b4[6:5]}));
                    cnt = NUM_W'(5);
                end
                ttfd_pkg::TYPE_SUPPLY: begin
                    n_res[1].id    = ttfd_pkg::FID_RC_VOLT;
                    n_res[1].value = $signed(21'(b3));
                    n_res[2].id    = ttfd_pkg::FID_PWR_VOLT;
                    n_res[2].value = $signed(21'(b4));
                    n_res[3].id    = ttfd_pkg::FID_PUMP_VOLT;
                    n_res[3].value = $signed(21'(b5));
                    cnt = NUM_W'(4);
                end
                ttfd_pkg::TYPE_THROTTLE: begin
                    n_res[1].id    = ttfd_pkg::FID_THROTTLE;
                    n_res[1].value = $signed(21'((b3 > ttfd_pkg::THROTTLE_MAX) ?
                                                 ttfd_pkg::THROTTLE_MAX : b3));
                    n_res[2].id    = ttfd_pkg::FID_PRESSURE;
                    n_res[2].value = $signed(21'({b5, b4, 1'b0}));
                    cnt = NUM_W'(3);
                end
                ttfd_pkg::TYPE_THRUST: begin
                    n_res[1].id    = ttfd_pkg::FID_CURRENT;
                    n_res[1].value = $signed(21'({b4[0], b3}));
                    n_res[2].id    = ttfd_pkg::FID_THRUST;
                    n_res[2].value = $signed(21'({b4[7:1], b5}));
                    cnt = NUM_W'(3);
                end
                ttfd_pkg::TYPE_IGNITION: begin
                    n_res[1].id    = ttfd_pkg::FID_IGN_VOLT;
                    n_res[1].value = $signed(21'({b3, 1'b0}));
                    n_res[2].id    = ttfd_pkg::FID_RPM_ACCEL;
                    n_res[2].value = $signed(21'(accel));
                    cnt = NUM_W'(3);
                end
                ttfd_pkg::TYPE_LIMITS: begin
                    n_res[1].id    = ttfd_pkg::FID_MAX_RPM;
                    n_res[1].value = $signed(21'(kilo));
                    n_res[2].id    = ttfd_pkg::FID_PUMP_MAX;
                    n_res[2].value = $signed(21'(b4));
                    n_res[3].id    = ttfd_pkg::FID_VERSION;
                    n_res[3].value = $signed(21'(b5[7:2]));
                    n_res[4].id    = ttfd_pkg::FID_UPD_RATE;
                    n_res[4].value = $signed(21'(b5[1:0]));
                    cnt = NUM_W'(5);
                end
                ttfd_pkg::TYPE_FLOW: begin
                    n_res[1].id    = ttfd_pkg::FID_FLOW_RATE;
                    n_res[1].value = $signed(21'({b4[1:0], b3}));
                    n_res[2].id    = ttfd_pkg::FID_FLOW_TOTAL;
                    n_res[2].value = $signed(21'({b5, b4[7:2]}));
                    cnt = NUM_W'(3);
                end
                ttfd_pkg::TYPE_IDLE: begin
                    n_res[1].id    = ttfd_pkg::FID_IDLE_RPM;
                    n_res[1].value = $signed(21'(kilo));
                    cnt = NUM_W'(2);
                end
                default: begin
                    cnt = NUM_W'(1);
                end
            endcase
        end

        // mark the final result of the packet
        for (int i = 0; i < MAX_RES; i++) begin
            n_res[i].last = (NUM_W'(i + 1) == cnt);
        end
        n_res_num = cnt;
    end

    // result queue: load on a packet end, otherwise shift down on each taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_num <= '0;
        end else if (w_proc && r_in_end) begin
            r_res_num <= n_res_num;
        end else if (w_pop) begin
            r_res_num <= r_res_num - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_end) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_res[i] <= n_res[i];
            end
        end else if (w_pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_res[i] <= r_res[i + 1];
            end
        end
    end

    // output side straight from the queue head
    assign m_axis_tvalid = (r_res_num != '0);
    assign m_axis_tdata  = {6'b0, r_res[0].value, r_res[0].id};
    assign m_axis_tuser  = r_res[0].kind;
    assign m_axis_tlast  = r_res[0].last;

    // checks
    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_num <= NUM_W'(MAX_RES))
        else $error("result queue overfilled");

    a_last_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (r_res_num == NUM_W'(1))))
        else $error("last flag not on final queued result");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ttfd_pkg::KIND_FIELD))
            |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("error result not single and zero");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_end) |=> ((r_count == '0) && (r_crc == '0)))
        else $error("packet end did not clear count and CRC");

endmodule

/* bench/turbine_telemetry_frame_decoder_tb.sv */
// Self-checking bench for turbine_telemetry_frame_decoder: byte requests with random gaps,
// a scoreboard that predicts every decoded field or error result and checks the output stream.
// Depends on ttfd_pkg and the decoder RTL.
module turbine_telemetry_frame_decoder_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 50;
    localparam int CALM_BYTES   = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    // Predicts the result stream of the decoder from the accepted byte requests
    class frame_scoreboard;
        logic [7:0]     frame_bytes [ttfd_pkg::FRAME_LEN];
        int             byte_cnt;
        logic [7:0]     crc_acc;
        ttfd_pkg::t_res result_q [$];
        int             errors;

        function new();
            byte_cnt = 0;
            crc_acc  = 8'h00;
            errors   = 0;
        endfunction

        // reflected CRC-8 over one byte, LSB first
        function logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            repeat (8) begin
                c = {1'b0, c[7:1]} ^ (c[0] ? ttfd_pkg::CRC_POLY_REF : 8'h00);
            end
            return c;
        endfunction

        function void push_result(input logic [ttfd_pkg::KIND_W-1:0] kind,
                                  input logic [ttfd_pkg::ID_W-1:0] id,
                                  input int val, input logic fin);
            ttfd_pkg::t_res r;
            r.kind  = kind;
            r.id    = id;
            r.value = val[ttfd_pkg::VALUE_W-1:0];
            r.last  = fin;
            result_q.push_back(r);
        endfunction

        // one accepted byte: store, update CRC, decode on the end mark
        function void note_byte(input logic [7:0] b, input logic pkt_end);
            logic [ttfd_pkg::ID_W-1:0] ids [ttfd_pkg::MAX_RES];
            int vals [ttfd_pkg::MAX_RES];
            int n, b1, b2, b3, b4, b5, t;
            if (byte_cnt < ttfd_pkg::FRAME_LEN)
                frame_bytes[byte_cnt] = b;
            if (byte_cnt < ttfd_pkg::FRAME_LEN - 1)
                crc_acc = crc_update(crc_acc, b);
            if (byte_cnt < ttfd_pkg::COUNT_SAT)
                byte_cnt++;
            if (!pkt_end)
                return;

            if (byte_cnt != ttfd_pkg::FRAME_LEN) begin
                push_result(ttfd_pkg::KIND_LENGTH, ttfd_pkg::FID_RPM, 0, 1'b1);
            end else if (crc_acc != frame_bytes[ttfd_pkg::FRAME_LEN-1]) begin
                push_result(ttfd_pkg::KIND_CHECKSUM, ttfd_pkg::FID_RPM, 0, 1'b1);
            end else begin
                b1 = frame_bytes[1];
                b2 = frame_bytes[2];
                b3 = frame_bytes[3];
                b4 = frame_bytes[4];
                b5 = frame_bytes[5];
                ids[0]  = ttfd_pkg::FID_RPM;
                vals[0] = (b1 | (b2 << 8)) * 10;
                n = 1;
                case (frame_bytes[0][3:0])
                    ttfd_pkg::TYPE_STATUS: begin
                        t = ((b4 & 'h1C) << 6) | b5;
                        ids[1] = ttfd_pkg::FID_STATUS; vals[1] = b3 & 'h1F;
                        ids[2] = ttfd_pkg::FID_ERROR;
                        vals[2] = (((b3 & 'hE0) >> 5) | ((b4 & 'h03) << 3)) & 'h1F;
                        ids[3] = ttfd_pkg::FID_TEMP;   vals[3] = t - ttfd_pkg::TEMP_OFFSET;
                        ids[4] = ttfd_pkg::FID_SWITCH; vals[4] = (b4 & 'h60) >> 5;
                        n = 5;
                    end
                    ttfd_pkg::TYPE_SUPPLY: begin
                        ids[1] = ttfd_pkg::FID_RC_VOLT;   vals[1] = b3;
                        ids[2] = ttfd_pkg::FID_PWR_VOLT;  vals[2] = b4;
                        ids[3] = ttfd_pkg::FID_PUMP_VOLT; vals[3] = b5;
                        n = 4;
                    end
                    ttfd_pkg::TYPE_THROTTLE: begin
                        ids[1] = ttfd_pkg::FID_THROTTLE;
                        vals[1] = (b3 > int'(ttfd_pkg::THROTTLE_MAX)) ?
                                  int'(ttfd_pkg::THROTTLE_MAX) : b3;
                        ids[2] = ttfd_pkg::FID_PRESSURE; vals[2] = (b4 | (b5 << 8)) * 2;
                        n = 3;
                    end
                    ttfd_pkg::TYPE_THRUST: begin
                        ids[1] = ttfd_pkg::FID_CURRENT; vals[1] = (b3 | (b4 << 8)) & 'h1FF;
                        ids[2] = ttfd_pkg::FID_THRUST;
                        vals[2] = (b5 | ((b4 & 'hFE) << 7)) & 'h7FFF;
                        n = 3;
                    end
                    ttfd_pkg::TYPE_IGNITION: begin
                        t = b4;
                        if (t < int'(ttfd_pkg::ACCEL_MIN)) t = int'(ttfd_pkg::ACCEL_MIN);
                        if (t > int'(ttfd_pkg::ACCEL_MAX)) t = int'(ttfd_pkg::ACCEL_MAX);
                        ids[1] = ttfd_pkg::FID_IGN_VOLT;  vals[1] = b3 * 2;
                        ids[2] = ttfd_pkg::FID_RPM_ACCEL; vals[2] = t;
                        n = 3;
                    end
                    ttfd_pkg::TYPE_LIMITS: begin
                        ids[1] = ttfd_pkg::FID_MAX_RPM;
                        vals[1] = b3 * int'(ttfd_pkg::RPM_SCALE_K);
                        ids[2] = ttfd_pkg::FID_PUMP_MAX; vals[2] = b4;
                        ids[3] = ttfd_pkg::FID_VERSION;  vals[3] = (b5 >> 2) & 'h3F;
                        ids[4] = ttfd_pkg::FID_UPD_RATE; vals[4] = b5 & 'h03;
                        n = 5;
                    end
                    ttfd_pkg::TYPE_FLOW: begin
                        ids[1] = ttfd_pkg::FID_FLOW_RATE;
                        vals[1] = (b3 | (b4 << 8)) & 'h3FF;
                        ids[2] = ttfd_pkg::FID_FLOW_TOTAL;
                        vals[2] = ((b4 >> 2) | (b5 << 6)) & 'h3FFF;
                        n = 3;
                    end
                    ttfd_pkg::TYPE_IDLE: begin
                        ids[1] = ttfd_pkg::FID_IDLE_RPM;
                        vals[1] = b3 * int'(ttfd_pkg::RPM_SCALE_K);
                        n = 2;
                    end
                    default: begin
                        n = 1;
                    end
                endcase
                for (int k = 0; k < n; k++)
                    push_result(ttfd_pkg::KIND_FIELD, ids[k], vals[k], k == n - 1);
            end
            byte_cnt = 0;
            crc_acc  = 8'h00;
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(input logic [ttfd_pkg::KIND_W-1:0] kind,
                                   input logic [ttfd_pkg::ID_W-1:0] id,
                                   input logic signed [ttfd_pkg::VALUE_W-1:0] value,
                                   input logic fin);
            ttfd_pkg::t_res want;
            if (result_q.size() == 0) begin
                errors++;
                $display({"%0t: unexpected result, expected none, ",
                          "actual kind %0d id %0d value %0d last %0d"},
                         $time, kind, id, value, fin);
                return;
            end
            want = result_q.pop_front();
            if (kind !== want.kind) begin
                errors++;
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
            end
            if (id !== want.id) begin
                errors++;
                $display("%0t: field_id expected %0d actual %0d", $time, want.id, id);
            end
            if (value !== want.value) begin
                errors++;
                $display("%0t: field_value expected %0d actual %0d", $time, want.value, value);
            end
            if (fin !== want.last) begin
                errors++;
                $display("%0t: last expected %0d actual %0d", $time, want.last, fin);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tlast;   // packet_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [4:0] field_id, [25:5] field_value, [31:26] zero
    logic [1:0]  m_axis_tuser;   // [1:0] result_kind
    logic        m_axis_tlast;   // last

    frame_scoreboard sb = new();
    logic [7:0]      pkt_q [$];
    int              sent_cnt  = 0;
    int              cycle_cnt = 0;
    bit              idle_on   = 1'b1;
    bit              hold_req  = 1'b0;

    turbine_telemetry_frame_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("turbine_telemetry_frame_decoder test failed");
            $finish;
        end
    end

    // observe both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[25:5], m_axis_tlast);
    end

    // one byte request, with an optional random gap in front of it
    task automatic send_byte(input logic [7:0] b, input logic pkt_end);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= pkt_end;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sent_cnt++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    // seven-byte frame with a correct or a deliberately broken CRC
    task automatic send_frame(input logic [7:0] b0, input logic [39:0] body, input bit corrupt);
        logic [7:0] crc;
        pkt_q = {};
        pkt_q.push_back(b0);
        for (int i = 0; i < 5; i++)
            pkt_q.push_back(body[8*i +: 8]);
        crc = 8'h00;
        foreach (pkt_q[i])
            crc = sb.crc_update(crc, pkt_q[i]);
        if (corrupt)
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        pkt_q.push_back(crc);
        send_packet();
    endtask

    // packet of random bytes and a given length
    task automatic send_noise(input int len);
        pkt_q = {};
        repeat (len) pkt_q.push_back(8'($urandom));
        send_packet();
    endtask

    // receiver: random ready bursts, one long hold-off, steady ready at the end
    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!idle_on) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
        end
    end

    // reset, directed frames, random traffic, drain and verdict
    initial begin
        int         rand_end;
        int         pick;
        int         len;
        logic [7:0] b0;
        logic [39:0] body;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // low extremes: temperature offset, accel clamp, zero throttle, unused type
        send_frame({4'h0, 4'h0}, 40'h0, 1'b0);
        send_frame({4'h0, ttfd_pkg::TYPE_STATUS}, 40'h0, 1'b0);
        send_frame({4'h0, ttfd_pkg::TYPE_THROTTLE}, 40'h0, 1'b0);
        send_frame({4'h0, ttfd_pkg::TYPE_IGNITION}, 40'h0, 1'b0);
        // high extremes for every frame type and an unused one
        for (int t = 1; t <= 8; t++) begin
            b0 = {4'hF, 4'h0};
            b0[3:0] = t[3:0];
            send_frame(b0, {40{1'b1}}, 1'b0);
        end
        send_frame(8'hFF, {40{1'b1}}, 1'b0);
        // short, one-over, saturating and checksum-broken packets
        send_noise(1);
        send_noise(6);
        send_noise(8);
        send_noise(12);
        send_frame({4'h5, ttfd_pkg::TYPE_SUPPLY}, 40'h12_34_56_78_9A, 1'b1);
        send_frame({4'hA, ttfd_pkg::TYPE_LIMITS}, 40'h80_40_20_10_08, 1'b0);

        // random traffic, mostly good frames; the receiver holds off first
        hold_req = 1'b1;
        rand_end = sent_cnt + RANDOM_BYTES;
        while (sent_cnt < rand_end) begin
            if (sent_cnt >= rand_end - CALM_BYTES)
                idle_on = 1'b0;
            pick = $urandom_range(0, 9);
            b0   = 8'($urandom);
            body = {$urandom, 8'($urandom)};
            if (pick <= 6) begin
                b0[3:0] = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 8));
                send_frame(b0, body, 1'b0);
            end else if (pick == 7) begin
                send_frame(b0, body, 1'b1);
            end else if (pick == 8) begin
                len = $urandom_range(1, 11);
                if (len >= ttfd_pkg::FRAME_LEN)
                    len++;
                send_noise(len);
            end else begin
                send_frame(b0, body, 1'b0);
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.result_q.size() == 0)
            $display("turbine_telemetry_frame_decoder test passed");
        else
            $display("turbine_telemetry_frame_decoder test failed");
        $finish;
    end

endmodule

/* turbine_telemetry_frame_decoder.f */
hdl/ttfd_pkg.sv
hdl/turbine_telemetry_frame_decoder.sv
bench/turbine_telemetry_frame_decoder_tb.sv
